@@ hdl/osr_pkg.sv @@
`timescale 1ns / 1ps
package osr_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned RANK_W       = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SR_CHK,
    ST_SR_CMP,
    ST_MV_RD,
    ST_MV_WR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              status;
  } res_t;

endpackage

@@ hdl/osr_store.sv @@
`timescale 1ns / 1ps
module osr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [osr_pkg::KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [osr_pkg::KEY_W-1:0] rdata_o
);
  import osr_pkg::*;

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/osr_ctrl.sv @@
`timescale 1ns / 1ps
module osr_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [osr_pkg::OP_W-1:0]  in_op_i,
  input  logic [osr_pkg::KEY_W-1:0] in_key_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output osr_pkg::res_t             res_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [osr_pkg::KEY_W-1:0] mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [osr_pkg::KEY_W-1:0] mem_rdata_i
);
  import osr_pkg::*;

  localparam int unsigned RW = (CW + 1 > RANK_W) ? CW + 1 : RANK_W;

  state_e           state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;
  logic [CW-1:0]    j_q, j_d;
  logic [CW-1:0]    count_q, count_d;
  logic             found_q, found_d;
  res_t             res_q, res_d;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW:0]      j_inc;
  logic [CW-1:0]    j_dec;
  logic [RW-1:0]    rank_wide;
  logic             full;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CW:1];
  assign j_inc     = {1'b0, j_q} + (CW+1)'(1);
  assign j_dec     = j_q - CW'(1);
  assign rank_wide = RW'(lo_q) + RW'(1);
  assign full      = (count_q == CW'(CAPACITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    j_d         = j_q;
    count_d     = count_q;
    found_d     = found_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = j_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = mid[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_op_i;
          key_d   = in_key_i;
          lo_d    = '0;
          hi_d    = count_q;
          found_d = 1'b0;
          res_d   = '0;
          state_d = ST_SR_CHK;
        end
      end

      ST_SR_CHK: begin
        if (lo_q < hi_q) begin
          state_d = ST_SR_CMP;
        end else begin
          state_d = ST_FIN;
          case (op_q)
            OP_INSERT: begin
              if (!found_q && full) begin
                res_d.status = 1'b1;
              end else if (!found_q) begin
                j_d     = count_q;
                state_d = ST_MV_RD;
              end
            end
            OP_DELETE: begin
              if (found_q) begin
                j_d     = lo_q;
                state_d = ST_MV_RD;
              end
            end
            OP_QUERY: begin
              if (found_q) begin
                res_d.rank = rank_wide[RANK_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SR_CMP: begin
        state_d = ST_SR_CHK;
        if (mem_rdata_i == key_q) begin
          found_d = 1'b1;
          hi_d    = mid;
        end else if ($signed(mem_rdata_i) < $signed(key_q)) begin
          lo_d = mid + CW'(1);
        end else begin
          hi_d = mid;
        end
      end

      ST_MV_RD: begin
        if (op_q == OP_INSERT) begin
          if (j_q > lo_q) begin
            mem_raddr_o = j_dec[AW-1:0];
            state_d     = ST_MV_WR;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = lo_q[AW-1:0];
            mem_wdata_o = key_q;
            count_d     = count_q + CW'(1);
            state_d     = ST_FIN;
          end
        end else begin
          if (j_inc < {1'b0, count_q}) begin
            mem_raddr_o = j_inc[AW-1:0];
            state_d     = ST_MV_WR;
          end else begin
            count_d = count_q - CW'(1);
            state_d = ST_FIN;
          end
        end
      end

      ST_MV_WR: begin
        mem_we_o = 1'b1;
        state_d  = ST_MV_RD;
        if (op_q == OP_INSERT) begin
          j_d = j_dec;
        end else begin
          j_d = j_inc[CW-1:0];
        end
      end

      ST_FIN: begin
        res_valid_o = res_ready_i;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
    else $error("Entry count moved by more than one.");

  a_drop_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status |-> res_o.rank == '0 && op_q == OP_INSERT)
    else $error("Dropped insert reported a rank.");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> {1'b0, mem_waddr_o} < (AW+1)'(CAPACITY))
    else $error("Store write beyond capacity.");

endmodule

@@ hdl/ordered_set_with_rank_unit.sv @@
`timescale 1ns / 1ps
// Each operation runs a binary search over the key store; with its registered read port,
// every probe passes through ST_SR_CHK and ST_SR_CMP. An insert or delete that changes the
// store then moves entries one at a time through ST_MV_RD and ST_MV_WR, and one more
// ST_MV_RD ends the move, before ST_FIN issues the result transaction.
// Throughput: one transaction at a time; s_axis_tready is high only between operations.
// Reset: rst_ni clears the entry count and the controller; the store itself is not cleared.
module ordered_set_with_rank_unit #(
  parameter int unsigned CAPACITY = osr_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key[31:0]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // rank[6:0], zero[7]
  output logic [0:0]  m_axis_tuser    // status[0]
);
  import osr_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rdata;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q, out_res_d;

  osr_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  osr_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_key_i    (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.rank};
  assign m_axis_tuser  = out_res_q.status;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import osr_pkg::*;

  localparam int unsigned Capacity = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OpUnused = 2'd3;
  localparam logic signed [KEY_W-1:0] MinKey = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] MaxKey = 32'sh7fff_ffff;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  logic signed [KEY_W-1:0] held_keys[$];
  logic signed [KEY_W-1:0] key_pool[$];
  res_t                    pending_results[$];
  int                      err_count = 0;
  int                      ready_hold = 0;
  bit                      no_idle = 1'b0;

  ordered_set_with_rank_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The set is kept as a sorted queue; signed compares give the key order.
  function automatic res_t apply_set_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    int   pos;
    bit   hit;
    res_t res;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < key) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == key);
    res = '0;
    case (op)
      OP_INSERT: begin
        if (!hit) begin
          if (held_keys.size() >= Capacity) res.status = 1'b1;
          else held_keys.insert(pos, key);
        end
      end
      OP_DELETE: begin
        if (hit) held_keys.delete(pos);
      end
      OP_QUERY: begin
        if (hit) res.rank = RANK_W'(pos + 1);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_set_op(op, key));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [OP_W-1:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_INSERT;
    if (r < 65) return OP_DELETE;
    if (r < 94) return OP_QUERY;
    return OpUnused;
  endfunction

  task automatic run_pool_traffic(int n_items, int pool_size);
    logic signed [KEY_W-1:0] key;
    key_pool.delete();
    key_pool.push_back(MinKey);
    key_pool.push_back(MaxKey);
    while (key_pool.size() < pool_size) key_pool.push_back($urandom);
    for (int i = 0; i < n_items; i++) begin
      no_idle = (i % 100) >= 70;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_op(random_op(), key);
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_directed();
    send_op(OP_QUERY, MinKey);
    send_op(OP_DELETE, 0);
    send_op(OP_INSERT, MinKey);
    send_op(OP_INSERT, MaxKey);
    send_op(OP_INSERT, 0);
    send_op(OP_INSERT, -1);
    send_op(OP_INSERT, 1);
    send_op(OP_QUERY, MinKey);
    send_op(OP_QUERY, MaxKey);
    send_op(OP_QUERY, -1);
    send_op(OP_QUERY, 0);
    send_op(OP_QUERY, 5);
    send_op(OP_INSERT, 0);
    send_op(OP_DELETE, 0);
    send_op(OP_QUERY, 0);
    send_op(OP_QUERY, 1);
    send_op(OpUnused, MaxKey);
    send_op(OpUnused, -1);
    send_op(OP_DELETE, MinKey);
    send_op(OP_QUERY, MaxKey);
    send_op(OP_DELETE, MaxKey);
    send_op(OP_DELETE, -1);
    send_op(OP_DELETE, 1);
    send_op(OP_QUERY, 1);
    drain_results();
  endtask

  task automatic test_full_store();
    logic signed [KEY_W-1:0] key;
    no_idle = 1'b1;
    for (int i = 0; i < Capacity; i++) send_op(OP_INSERT, $urandom);
    no_idle = 1'b0;
    for (int i = 0; i < 3; i++) send_op(OP_INSERT, $urandom);
    key = held_keys[0];
    send_op(OP_INSERT, key);
    send_op(OP_QUERY, key);
    send_op(OP_QUERY, held_keys[held_keys.size() - 1]);
    send_op(OP_DELETE, held_keys[Capacity / 2]);
    send_op(OP_INSERT, key + 1);
    send_op(OP_INSERT, $urandom);
    for (int i = 0; i < 4; i++) send_op(OP_QUERY, held_keys[$urandom_range(0, Capacity - 1)]);
    drain_results();
  endtask

  task automatic test_empty_store();
    logic signed [KEY_W-1:0] victims[$];
    int                      idx;
    victims = held_keys;
    while (victims.size() != 0) begin
      idx = $urandom_range(0, victims.size() - 1);
      send_op(OP_DELETE, victims[idx]);
      victims.delete(idx);
    end
    send_op(OP_QUERY, MaxKey);
    drain_results();
  endtask

  // Results are checked and the downstream stall pattern is chosen here.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[RANK_W-1:0] !== want.rank) begin
          $display("%0t: rank mismatch, expected %0d, actual %0d",
                   $time, want.rank, m_axis_tdata[RANK_W-1:0]);
          err_count++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $display("%0t: tdata pad bit mismatch, expected 0, actual %b", $time, m_axis_tdata[7]);
          err_count++;
        end
        if (m_axis_tuser[0] !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %b",
                   $time, want.status, m_axis_tuser[0]);
          err_count++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          m_axis_tready <= 1'b0;
          ready_hold = $urandom_range(0, 3);
        end
        2: begin
          m_axis_tready <= 1'b0;
          ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : 1;
        end
        default: begin
          m_axis_tready <= 1'b1;
          ready_hold = $urandom_range(0, 4);
        end
      endcase
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_full_store();
    run_pool_traffic(300, 96);
    test_empty_store();
    run_pool_traffic(120, 12);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
